// ----- hw/rtl/scl_pkg.sv -----
// Shared types and constants for the sight line occluder check block.
package scl_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 64;
    localparam int FIELD_W  = 32;
    localparam int WORK_W   = 9;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_EMPTY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUDGET = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    localparam logic [WORK_W-1:0] LIMIT_RESET = 9'd256;

    // Input tdata layout
    localparam int IN_DATA_W = 384;
    localparam int OFS_ID    = 0;
    localparam int OFS_AX    = 64;
    localparam int OFS_AY    = 96;
    localparam int OFS_BX    = 128;
    localparam int OFS_BY    = 160;
    localparam int OFS_WL    = 192;
    localparam int OFS_OX    = 224;
    localparam int OFS_OY    = 256;
    localparam int OFS_TX    = 288;
    localparam int OFS_TY    = 320;
    localparam int OFS_QL    = 352;

    // Output tdata width
    localparam int OUT_DATA_W = 80;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic issue;
        logic walk;
        logic finish;
        logic push;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic issue_done;
        logic pipe_empty;
        logic stop;
    } sts_t;

endpackage

// ----- hw/rtl/scl_ram.sv -----
// Generic single write port RAM with registered read.
module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hw/rtl/scl_ctrl.sv -----
// Controller state machine: handshakes, query sequencing and result hand-off.
module scl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             mode,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output scl_pkg::cmd_t          cmd,
    input  scl_pkg::sts_t          sts
);
    import scl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP1 = 3'd1;
    localparam logic [2:0] S_PREP2 = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, push, finish;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && (state_reg == S_IDLE);
    assign push     = (state_reg == S_PUSH) && (!out_valid_reg || m_tready);
    assign finish   = (state_reg == S_WALK) && !sts.stop && sts.issue_done && sts.pipe_empty;

    // Commands
    always_comb
    begin
        cmd.accept = accept;
        cmd.issue  = (state_reg == S_WALK) && !sts.issue_done;
        cmd.walk   = (state_reg == S_WALK);
        cmd.finish = finish;
        cmd.push   = push;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode == MODE_QUERY) ? S_PREP1 : S_PUSH;
                end
            end
            S_PREP1: state_next = S_PREP2;
            S_PREP2: state_next = S_WALK;
            S_WALK:
            begin
                if (sts.stop || finish)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- hw/rtl/scl_dp.sv -----
// Datapath: wall table, pipelined wall test, work counter and result registers.
module scl_dp #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scl_pkg::cmd_t                   cmd,
    output scl_pkg::sts_t                   sts,
    input  logic [1:0]                      mode,
    input  logic [scl_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                            cfg_we,
    input  logic [scl_pkg::WORK_W-1:0]      cfg_wdata,
    output logic [scl_pkg::STATUS_W-1:0]    out_status,
    output logic                            out_clear,
    output logic [scl_pkg::ID_W-1:0]        out_id,
    output logic [scl_pkg::WORK_W-1:0]      out_work
);
    import scl_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CB    = COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * COORD_BITS + 2;
    localparam int SW    = PW + 1;
    localparam int RAM_W = ID_W + 4 * COORD_BITS + FIELD_W;

    // Table fill count and work limit
    logic [CW-1:0]     count_reg;
    logic [WORK_W-1:0] limit_reg;
    logic              full, table_we;

    // Query setup registers
    logic signed [CB-1:0] ox_reg, oy_reg, tx_reg, ty_reg;
    logic [FIELD_W-1:0]   qmask_reg;
    logic signed [DW-1:0] dtx_reg, dty_reg;
    logic [DW-1:0]        magx, magy;
    logic                 use_x_reg, same_reg;
    logic signed [CB-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;

    // Walk control
    logic [CW-1:0]     idx_reg;
    logic [WORK_W-1:0] work_reg;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;

    // Table read data
    logic [RAM_W-1:0]     rd_data;
    logic [RAM_W-1:0]     wr_data;
    logic signed [CB-1:0] ax, ay, bx, by;
    logic [FIELD_W-1:0]   wmask;
    logic                 match1, onr1, ov1;
    logic signed [CB-1:0] wa, wb, rmin, rmax;

    // Stage 2: differences
    logic signed [DW-1:0] aox2, aoy2, box2, boy2, wx2, wy2, oax2, oay2, tax2, tay2;
    logic [ID_W-1:0]      id2, id3, id4;
    logic                 match2, onr2, ov2, match3, onr3, ov3, match4, onr4, ov4;

    // Stage 3: products
    logic signed [PW-1:0] p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;

    // Stage 4: orientation signs
    logic signed [SW-1:0] s1, s2, s3, s4;
    logic o1n, o1z, o2n, o2z, o3n, o3z, o4n, o4z;
    logic o1p, o2p, o3p, o4p;

    // End stage
    logic blk, act, budget, hit, stop;

    // Result registers
    logic [STATUS_W-1:0] res_status;
    logic                res_clear;
    logic [ID_W-1:0]     res_id;
    logic [WORK_W-1:0]   res_work;

    assign full     = (count_reg >= CW'(TABLE_DEPTH));
    assign table_we = cmd.accept && (mode == MODE_APPEND) && !full;
    assign wr_data  = {in_data[OFS_WL +: FIELD_W], in_data[OFS_BY +: CB], in_data[OFS_BX +: CB],
                       in_data[OFS_AY +: CB], in_data[OFS_AX +: CB], in_data[OFS_ID +: ID_W]};

    scl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_data),
        .re    (cmd.issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // Fill count, limit, walk index and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
            idx_reg   <= '0;
            work_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (mode == MODE_EMPTY))
            begin
                count_reg <= '0;
            end
            else if (table_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.accept)
            begin
                work_reg <= '0;
            end
            else if (act && !budget)
            begin
                work_reg <= work_reg + WORK_W'(1);
            end
            v1_reg <= cmd.issue && !stop;
            v2_reg <= v1_reg && !stop;
            v3_reg <= v2_reg && !stop;
            v4_reg <= v3_reg && !stop;
        end
    end

    // Query coordinates, captured on every transfer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ox_reg    <= in_data[OFS_OX +: CB];
            oy_reg    <= in_data[OFS_OY +: CB];
            tx_reg    <= in_data[OFS_TX +: CB];
            ty_reg    <= in_data[OFS_TY +: CB];
            qmask_reg <= in_data[OFS_QL +: FIELD_W];
        end
    end

    // Query-constant terms, settled during the PREP1 and PREP2 states
    assign magx = dtx_reg[DW-1] ? DW'(-dtx_reg) : DW'(dtx_reg);
    assign magy = dty_reg[DW-1] ? DW'(-dty_reg) : DW'(dty_reg);

    always_ff @(posedge clk)
    begin
        dtx_reg   <= DW'(tx_reg) - DW'(ox_reg);
        dty_reg   <= DW'(ty_reg) - DW'(oy_reg);
        use_x_reg <= (magx >= magy);
        same_reg  <= (ox_reg == tx_reg) && (oy_reg == ty_reg);
        minx_reg  <= (ox_reg < tx_reg) ? ox_reg : tx_reg;
        maxx_reg  <= (ox_reg < tx_reg) ? tx_reg : ox_reg;
        miny_reg  <= (oy_reg < ty_reg) ? oy_reg : ty_reg;
        maxy_reg  <= (oy_reg < ty_reg) ? ty_reg : oy_reg;
    end

    // Stage 1: unpack wall, mask match and range tests
    assign ax    = rd_data[ID_W +: CB];
    assign ay    = rd_data[ID_W + CB +: CB];
    assign bx    = rd_data[ID_W + 2 * CB +: CB];
    assign by    = rd_data[ID_W + 3 * CB +: CB];
    assign wmask = rd_data[ID_W + 4 * CB +: FIELD_W];

    assign match1 = |(wmask & qmask_reg);
    assign onr1   = ((ax <= tx_reg && tx_reg <= bx) || (bx <= tx_reg && tx_reg <= ax)) &&
                    ((ay <= ty_reg && ty_reg <= by) || (by <= ty_reg && ty_reg <= ay));
    assign wa     = use_x_reg ? ax : ay;
    assign wb     = use_x_reg ? bx : by;
    assign rmin   = use_x_reg ? minx_reg : miny_reg;
    assign rmax   = use_x_reg ? maxx_reg : maxy_reg;
    // collinear overlap of positive length along the dominant axis
    assign ov1    = (rmax > rmin) && (wa != wb) && (rmax > wa || rmax > wb) &&
                    (wa > rmin || wb > rmin);

    always_ff @(posedge clk)
    begin
        aox2   <= DW'(ax) - DW'(ox_reg);
        aoy2   <= DW'(ay) - DW'(oy_reg);
        box2   <= DW'(bx) - DW'(ox_reg);
        boy2   <= DW'(by) - DW'(oy_reg);
        wx2    <= DW'(bx) - DW'(ax);
        wy2    <= DW'(by) - DW'(ay);
        oax2   <= DW'(ox_reg) - DW'(ax);
        oay2   <= DW'(oy_reg) - DW'(ay);
        tax2   <= DW'(tx_reg) - DW'(ax);
        tay2   <= DW'(ty_reg) - DW'(ay);
        id2    <= rd_data[ID_W-1:0];
        match2 <= match1;
        onr2   <= onr1;
        ov2    <= ov1;
    end

    // Stage 2: cross products
    always_ff @(posedge clk)
    begin
        p1a    <= PW'(dtx_reg) * PW'(aoy2);
        p1b    <= PW'(dty_reg) * PW'(aox2);
        p2a    <= PW'(dtx_reg) * PW'(boy2);
        p2b    <= PW'(dty_reg) * PW'(box2);
        p3a    <= PW'(wx2) * PW'(oay2);
        p3b    <= PW'(wy2) * PW'(oax2);
        p4a    <= PW'(wx2) * PW'(tay2);
        p4b    <= PW'(wy2) * PW'(tax2);
        id3    <= id2;
        match3 <= match2;
        onr3   <= onr2;
        ov3    <= ov2;
    end

    // Stage 3: orientation signs
    assign s1 = SW'(p1a) - SW'(p1b);
    assign s2 = SW'(p2a) - SW'(p2b);
    assign s3 = SW'(p3a) - SW'(p3b);
    assign s4 = SW'(p4a) - SW'(p4b);

    always_ff @(posedge clk)
    begin
        o1n    <= s1[SW-1];
        o1z    <= (s1 == '0);
        o2n    <= s2[SW-1];
        o2z    <= (s2 == '0);
        o3n    <= s3[SW-1];
        o3z    <= (s3 == '0);
        o4n    <= s4[SW-1];
        o4z    <= (s4 == '0);
        id4    <= id3;
        match4 <= match3;
        onr4   <= onr3;
        ov4    <= ov3;
    end

    // Stage 4: block decision, budget and stop
    assign o1p = !o1n && !o1z;
    assign o2p = !o2n && !o2z;
    assign o3p = !o3n && !o3z;
    assign o4p = !o4n && !o4z;

    assign blk = !same_reg &&
                 ((o4z && onr4) ||
                  (((o1n && o2p) || (o1p && o2n)) && ((o3n && o4p) || (o3p && o4n))) ||
                  (o1z && o2z && ov4));

    assign act    = cmd.walk && v4_reg && match4;
    assign budget = act && (work_reg >= limit_reg);
    assign hit    = act && !budget && blk;
    assign stop   = budget || hit;

    always_comb
    begin
        sts.issue_done = (idx_reg >= count_reg);
        sts.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
        sts.stop       = stop;
    end

    // Result of the current item
    always_ff @(posedge clk)
    begin
        priority if (cmd.accept && (mode != MODE_QUERY))
        begin
            res_status <= ((mode == MODE_APPEND) && full) ? ST_FULL : ST_OK;
            res_clear  <= 1'b0;
            res_id     <= '0;
            res_work   <= '0;
        end
        else if (budget)
        begin
            res_status <= ST_BUDGET;
            res_clear  <= 1'b0;
            res_id     <= '0;
            res_work   <= work_reg;
        end
        else if (hit)
        begin
            res_status <= ST_OK;
            res_clear  <= 1'b0;
            res_id     <= id4;
            res_work   <= work_reg + WORK_W'(1);
        end
        else if (cmd.finish)
        begin
            res_status <= ST_OK;
            res_clear  <= 1'b1;
            res_id     <= '0;
            res_work   <= work_reg;
        end
        else
        begin
            res_status <= res_status;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_status <= res_status;
            out_clear  <= res_clear;
            out_id     <= res_id;
            out_work   <= res_work;
        end
    end

    // Checks
    a_work_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (work_reg <= limit_reg))
        else $error("work count passed the limit during a walk");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_stop_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(stop && cmd.finish))
        else $error("stop and finish in the same cycle");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        stop |=> !v4_reg && !v3_reg && !v2_reg)
        else $error("pipeline not flushed after stop");
endmodule

// ----- hw/rtl/sight_line_occluder_check_core.sv -----
// Empty/append items go from accept straight to push; queries pass PREP1, PREP2 and WALK, and
// a walk ends when all stored walls are walked or a wall stops it on a blocker or the work budget.
// Throughput: one wall test per cycle from a 4-stage test pipeline fed by the table RAM port.
// Items are taken one at a time; a result waits in the output register while the next is taken.
// Reset: table empty (RAM contents undefined), work limit 256, no result pending.
// Top level: stream ports, config register, controller and datapath.
module sight_line_occluder_check_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // segment_id, wall_ax, wall_ay, wall_bx, wall_by, wall_layers,
    // origin_x, origin_y, target_x, target_y, query_layers
    input  logic [scl_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  logic [scl_pkg::MODE_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // clear flag, blocker_id, work_count, zero fill
    output logic [scl_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status_code
    output logic [scl_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                             cfg_we,
    input  logic [scl_pkg::WORK_W-1:0]       cfg_wdata
);
    import scl_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic                out_clear;
    logic [ID_W-1:0]     out_id;
    logic [WORK_W-1:0]   out_work;

    scl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    scl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .mode       (s_tuser),
        .in_data    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_status (m_tuser),
        .out_clear  (out_clear),
        .out_id     (out_id),
        .out_work   (out_work)
    );

    // Pack result fields
    assign m_tdata = {{(OUT_DATA_W - 1 - ID_W - WORK_W){1'b0}}, out_work, out_id, out_clear};
endmodule
